>>> src/ssfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SYN filter bridge package
// Shared widths, codes and default table sizes.
// ----------------------------------------------------------------------------
package ssfb_pkg;
	localparam int MAC_ENTRIES_DEF   = 32;
	localparam int CONN_ENTRIES_DEF  = 32;
	localparam int BLOCK_ENTRIES_DEF = 32;

	localparam logic [15:0] ETH_IPV6   = 16'h86dd;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [47:0] MAC_BCAST  = 48'hffffffffffff;
	localparam logic [15:0] MCAST_PFX  = 16'h3333;

	localparam logic [1:0] FUNC_OUT    = 2'd0;
	localparam logic [1:0] FUNC_IN     = 2'd1;
	localparam logic [1:0] FUNC_NOTICE = 2'd2;

	localparam logic [1:0] ACT_DROP = 2'd0;
	localparam logic [1:0] ACT_SEND = 2'd1;
	localparam logic [1:0] ACT_TAP  = 2'd2;

	localparam logic [1:0] REG_LOCAL_HI = 2'd0;
	localparam logic [1:0] REG_LOCAL_LO = 2'd1;
	localparam logic [1:0] REG_BCAST_EP = 2'd2;
endpackage
`default_nettype wire

>>> src/stateful_syn_filter_bridge_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stateful SYN filter bridge core
// Firewall with MAC learning; tables are memories scanned one entry a cycle.
// ----------------------------------------------------------------------------
// A table lookup scans one entry per cycle; an item needs up to three lookups,
// a write and an output state before done rises.
// Throughput: one item at a time; busy falls with done and start is taken then.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears all valid bits and control registers at once; no clearing pass.
module stateful_syn_filter_bridge_core #(
	parameter int MAC_ENTRIES   = ssfb_pkg::MAC_ENTRIES_DEF,
	parameter int CONN_ENTRIES  = ssfb_pkg::CONN_ENTRIES_DEF,
	parameter int BLOCK_ENTRIES = ssfb_pkg::BLOCK_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] ethertype,
	input  wire logic [7:0]  ip_proto,
	input  wire logic        syn_flag,
	input  wire logic [15:0] tcp_src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [63:0] src_addr_hi,
	input  wire logic [63:0] src_addr_lo,
	input  wire logic [63:0] dst_addr_hi,
	input  wire logic [63:0] dst_addr_lo,
	input  wire logic [47:0] mac,
	input  wire logic [47:0] peer_endpoint,
	output logic             done,
	output logic [1:0]       action,
	output logic [47:0]      out_endpoint,
	output logic             notify_peers,
	output logic             table_full
);
	import ssfb_pkg::*;

	localparam int MW = $clog2(MAC_ENTRIES);
	localparam int CW = $clog2(CONN_ENTRIES);
	localparam int BW = $clog2(BLOCK_ENTRIES);
	localparam int SW = (MW > CW) ? ((MW > BW) ? MW : BW) : ((CW > BW) ? CW : BW);

	typedef enum logic [1:0] { T_MAC, T_CONN, T_BLOCK } tbl_t;
	typedef enum logic [2:0] { IDLE, SCAN, DECIDE, WRITE, OUT } state_t;
	typedef enum logic [2:0] {
		OP_OUT_MAC, OP_OUT_CONN, OP_IN_BLOCK, OP_IN_CONN, OP_IN_MAC, OP_NOTICE
	} op_t;

	logic [95:0]  mac_mem   [MAC_ENTRIES];
	logic [159:0] conn_mem  [CONN_ENTRIES];
	logic [127:0] block_mem [BLOCK_ENTRIES];
	logic [MAC_ENTRIES-1:0]   mac_vld_q;
	logic [CONN_ENTRIES-1:0]  conn_vld_q;
	logic [BLOCK_ENTRIES-1:0] block_vld_q;

	logic [63:0] loc_hi_q, loc_lo_q;
	logic [47:0] bcast_q;

	logic [15:0] ethertype_q, sport_q, dport_q;
	logic [7:0]  nh_q;
	logic        syn_q;
	logic [63:0] shi_q, slo_q, dhi_q, dlo_q;
	logic [47:0] mac_q, pep_q;

	state_t      state_q;
	op_t         op_q;
	logic [SW:0] addr_q;
	logic        rd_vld_s1;
	logic [SW:0] rd_idx_s1;
	logic        hit_q;
	logic [SW-1:0] hit_idx_q;
	logic [47:0] hit_ep_q;
	logic [1:0]  act_q;
	logic [47:0] ep_q;
	logic        notify_q, full_q;

	logic [95:0]  mac_rd_s1;
	logic [159:0] conn_rd_s1;
	logic [127:0] block_rd_s1;

	logic is_ipv6, is_tcp, mac_learnable;
	assign is_ipv6 = (ethertype_q == ETH_IPV6);
	assign is_tcp  = is_ipv6 && (nh_q == PROTO_TCP);
	assign mac_learnable = (mac_q != MAC_BCAST) && (mac_q[47:32] != MCAST_PFX);

	tbl_t tbl;
	logic [SW:0] depth;
	logic [159:0] conn_key;
	always_comb begin
		unique case (op_q)
			OP_OUT_MAC, OP_IN_MAC: tbl = T_MAC;
			OP_OUT_CONN, OP_IN_CONN: tbl = T_CONN;
			default: tbl = T_BLOCK;
		endcase
		unique case (tbl)
			T_MAC:  depth = (SW+1)'(MAC_ENTRIES);
			T_CONN: depth = (SW+1)'(CONN_ENTRIES);
			default: depth = (SW+1)'(BLOCK_ENTRIES);
		endcase
		if (op_q == OP_OUT_CONN)
			conn_key = {sport_q, dport_q, dhi_q, dlo_q};
		else
			conn_key = {dport_q, sport_q, shi_q, slo_q};
	end

	logic cmp_hit;
	always_comb begin
		unique case (tbl)
			T_MAC:  cmp_hit = mac_vld_q[rd_idx_s1[MW-1:0]] && (mac_rd_s1[95:48] == mac_q);
			T_CONN: cmp_hit = conn_vld_q[rd_idx_s1[CW-1:0]] && (conn_rd_s1 == conn_key);
			default: cmp_hit = block_vld_q[rd_idx_s1[BW-1:0]] &&
				(block_rd_s1 == {shi_q, slo_q});
		endcase
	end

	logic free_ok;
	logic [SW-1:0] free_idx;
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		unique case (tbl)
			T_MAC: for (int i = MAC_ENTRIES-1; i >= 0; i--)
				if (!mac_vld_q[i]) begin free_ok = 1'b1; free_idx = SW'(i); end
			T_CONN: for (int i = CONN_ENTRIES-1; i >= 0; i--)
				if (!conn_vld_q[i]) begin free_ok = 1'b1; free_idx = SW'(i); end
			default: for (int i = BLOCK_ENTRIES-1; i >= 0; i--)
				if (!block_vld_q[i]) begin free_ok = 1'b1; free_idx = SW'(i); end
		endcase
	end

	always_ff @(posedge clk) begin
		mac_rd_s1   <= mac_mem[addr_q[MW-1:0]];
		conn_rd_s1  <= conn_mem[addr_q[CW-1:0]];
		block_rd_s1 <= block_mem[addr_q[BW-1:0]];
		if (state_q == WRITE) begin
			unique case (tbl)
				T_MAC: begin
					if (hit_q)
						mac_mem[hit_idx_q[MW-1:0]] <= {mac_q, pep_q};
					else if (free_ok)
						mac_mem[free_idx[MW-1:0]] <= {mac_q, pep_q};
				end
				T_CONN: if (!hit_q && free_ok) conn_mem[free_idx[CW-1:0]] <= conn_key;
				default: if (!hit_q && free_ok)
					block_mem[free_idx[BW-1:0]] <= {shi_q, slo_q};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && start) begin
			ethertype_q <= ethertype; nh_q <= ip_proto;
			syn_q <= syn_flag; sport_q <= tcp_src_port; dport_q <= dst_port;
			shi_q <= src_addr_hi; slo_q <= src_addr_lo;
			dhi_q <= dst_addr_hi; dlo_q <= dst_addr_lo;
			mac_q <= mac; pep_q <= peer_endpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_hi_q <= '0; loc_lo_q <= '0; bcast_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_HI: loc_hi_q <= cfg_data;
				REG_LOCAL_LO: loc_lo_q <= cfg_data;
				REG_BCAST_EP: bcast_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE; op_q <= OP_NOTICE; addr_q <= '0; rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0; hit_q <= 1'b0; hit_idx_q <= '0; hit_ep_q <= '0;
			act_q <= ACT_DROP; ep_q <= '0; notify_q <= 1'b0; full_q <= 1'b0;
			mac_vld_q <= '0; conn_vld_q <= '0; block_vld_q <= '0;
			done <= 1'b0; action <= ACT_DROP; out_endpoint <= '0;
			notify_peers <= 1'b0; table_full <= 1'b0;
		end else begin
			done <= 1'b0;
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				IDLE: if (start) begin
					act_q <= ACT_DROP; ep_q <= '0; notify_q <= 1'b0; full_q <= 1'b0;
					hit_q <= 1'b0; addr_q <= '0;
					unique case (func)
						FUNC_OUT: begin op_q <= OP_OUT_MAC; state_q <= SCAN; end
						FUNC_IN: begin op_q <= OP_IN_BLOCK; state_q <= SCAN; end
						FUNC_NOTICE: begin op_q <= OP_NOTICE; state_q <= SCAN; end
						default: state_q <= OUT;
					endcase
					if (func == FUNC_IN && !(ethertype == ETH_IPV6 &&
						dst_addr_hi == loc_hi_q && dst_addr_lo == loc_lo_q))
						state_q <= OUT;
				end
				SCAN: begin
					if (rd_vld_s1 && cmp_hit && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_s1[SW-1:0];
						hit_ep_q <= mac_rd_s1[47:0];
					end
					if (addr_q != depth) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= addr_q;
						addr_q <= addr_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					state_q <= OUT;
					addr_q <= '0;
					unique case (op_q)
						OP_OUT_MAC: begin
							act_q <= ACT_SEND;
							ep_q <= hit_q ? hit_ep_q : bcast_q;
							if (is_tcp && syn_q) begin
								op_q <= OP_OUT_CONN; hit_q <= 1'b0; state_q <= SCAN;
							end
						end
						OP_IN_BLOCK: if (!hit_q) begin
							hit_q <= 1'b0;
							state_q <= SCAN;
							if (is_tcp) op_q <= OP_IN_CONN;
							else if (mac_learnable) op_q <= OP_IN_MAC;
							else state_q <= OUT;
						end
						OP_IN_CONN: begin
							hit_q <= 1'b0;
							if (!hit_q) begin
								notify_q <= 1'b1; op_q <= OP_NOTICE; state_q <= SCAN;
							end else if (mac_learnable) begin
								op_q <= OP_IN_MAC; state_q <= SCAN;
							end
						end
						OP_IN_MAC: begin act_q <= ACT_TAP; state_q <= WRITE; end
						default: state_q <= WRITE;
					endcase
				end
				WRITE: begin
					state_q <= OUT;
					if (!hit_q) begin
						if (!free_ok) full_q <= 1'b1;
						else unique case (tbl)
							T_MAC: mac_vld_q[free_idx[MW-1:0]] <= 1'b1;
							T_CONN: conn_vld_q[free_idx[CW-1:0]] <= 1'b1;
							default: block_vld_q[free_idx[BW-1:0]] <= 1'b1;
						endcase
					end
				end
				OUT: begin
					state_q <= IDLE;
					done <= 1'b1;
					action <= act_q;
					out_endpoint <= ep_q;
					notify_peers <= notify_q;
					table_full <= full_q;
				end
				default: state_q <= IDLE;
			endcase
			if (state_q == DECIDE && op_q == OP_OUT_CONN) state_q <= WRITE;
		end
	end

	assign busy = (state_q != IDLE);
endmodule
`default_nettype wire

>>> src/ssfb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SYN filter bridge checker
// Port-level assertions on the command and result timing.
// ----------------------------------------------------------------------------
module ssfb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [1:0] action,
	input wire logic       notify_peers
);
	import ssfb_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after accept");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_notify_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && notify_peers) |-> action == ACT_DROP) else $error("notify not dropped");
endmodule

bind stateful_syn_filter_bridge_core ssfb_checker u_ssfb_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.action(action), .notify_peers(notify_peers)
);
`default_nettype wire

>>> dv/stateful_syn_filter_bridge_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SYN filter bridge core testbench
// Drives frame headers and peer notices through the start/busy port and
// checks every strobed verdict against a table-based predictor. The run has
// directed cases first, then random traffic in several idling phases, with
// the address and broadcast registers rewritten while the block is idle.
// ----------------------------------------------------------------------------
module stateful_syn_filter_bridge_core_tb;
	import ssfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NMAC = MAC_ENTRIES_DEF;
	localparam int NCONN = CONN_ENTRIES_DEF;
	localparam int NBLK = BLOCK_ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 3 * (2 * (NMAC + 2) + 3);
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] ethertype;
		logic [7:0]  ip_proto;
		logic        syn_flag;
		logic [15:0] tcp_src_port;
		logic [15:0] dst_port;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [47:0] mac;
		logic [47:0] peer_ep;
	} frame_t;

	typedef struct {
		logic [1:0]  action;
		logic [47:0] endpoint;
		logic        notify;
		logic        full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_LOCAL_HI;
	logic [63:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy, done, notify_peers, table_full;
	logic [1:0] action;
	logic [47:0] out_endpoint;
	frame_t cur = '{default: '0};

	frame_t frame_queue[$];
	verdict_t expected_verdicts[$];
	int idle_pct = 0;
	int errors = 0;
	int cycles = 0;

	logic [63:0] lcl_hi = '0, lcl_lo = '0;
	logic [47:0] bcast_ep = '0;
	logic mac_v[NMAC];
	logic [47:0] mac_k[NMAC], mac_ep[NMAC];
	logic conn_v[NCONN];
	logic [31:0] conn_p[NCONN];
	logic [63:0] conn_hi[NCONN], conn_lo[NCONN];
	logic blk_v[NBLK];
	logic [63:0] blk_hi[NBLK], blk_lo[NBLK];

	logic [47:0] mac_pool[40];
	logic [47:0] ep_pool[8];
	logic [63:0] rem_hi[6], rem_lo[6];
	logic [15:0] lport_pool[4], rport_pool[4];

	stateful_syn_filter_bridge_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.func(cur.func), .ethertype(cur.ethertype), .ip_proto(cur.ip_proto),
		.syn_flag(cur.syn_flag), .tcp_src_port(cur.tcp_src_port),
		.dst_port(cur.dst_port),
		.src_addr_hi(cur.src_hi), .src_addr_lo(cur.src_lo),
		.dst_addr_hi(cur.dst_hi), .dst_addr_lo(cur.dst_lo),
		.mac(cur.mac), .peer_endpoint(cur.peer_ep),
		.done(done), .action(action), .out_endpoint(out_endpoint),
		.notify_peers(notify_peers), .table_full(table_full)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic block_hit(logic [63:0] hi, logic [63:0] lo);
		for (int i = 0; i < NBLK; i++)
			if (blk_v[i] && blk_hi[i] == hi && blk_lo[i] == lo) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic conn_hit(logic [31:0] p, logic [63:0] hi, logic [63:0] lo);
		for (int i = 0; i < NCONN; i++)
			if (conn_v[i] && conn_p[i] == p && conn_hi[i] == hi && conn_lo[i] == lo)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic block_add(logic [63:0] hi, logic [63:0] lo);
		if (block_hit(hi, lo)) return 1'b0;
		for (int i = 0; i < NBLK; i++)
			if (!blk_v[i]) begin
				blk_v[i] = 1'b1;
				blk_hi[i] = hi;
				blk_lo[i] = lo;
				return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic logic conn_add(logic [31:0] p, logic [63:0] hi, logic [63:0] lo);
		if (conn_hit(p, hi, lo)) return 1'b0;
		for (int i = 0; i < NCONN; i++)
			if (!conn_v[i]) begin
				conn_v[i] = 1'b1;
				conn_p[i] = p;
				conn_hi[i] = hi;
				conn_lo[i] = lo;
				return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic logic mac_learn(logic [47:0] key, logic [47:0] ep);
		for (int i = 0; i < NMAC; i++)
			if (mac_v[i] && mac_k[i] == key) begin
				mac_ep[i] = ep;
				return 1'b0;
			end
		for (int i = 0; i < NMAC; i++)
			if (!mac_v[i]) begin
				mac_v[i] = 1'b1;
				mac_k[i] = key;
				mac_ep[i] = ep;
				return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic verdict_t filter_decide(frame_t f);
		verdict_t v;
		logic ipv6, tcp, hit;
		v = '{action: ACT_DROP, endpoint: '0, notify: 1'b0, full: 1'b0};
		ipv6 = f.ethertype == ETH_IPV6;
		tcp = ipv6 && f.ip_proto == PROTO_TCP;
		case (f.func)
			FUNC_OUT: begin
				hit = 1'b0;
				v.endpoint = bcast_ep;
				for (int i = 0; i < NMAC; i++)
					if (!hit && mac_v[i] && mac_k[i] == f.mac) begin
						v.endpoint = mac_ep[i];
						hit = 1'b1;
					end
				v.action = ACT_SEND;
				if (tcp && f.syn_flag)
					v.full = conn_add({f.tcp_src_port, f.dst_port}, f.dst_hi, f.dst_lo);
			end
			FUNC_IN: begin
				if (ipv6 && f.dst_hi == lcl_hi && f.dst_lo == lcl_lo &&
						!block_hit(f.src_hi, f.src_lo)) begin
					if (tcp && !conn_hit({f.dst_port, f.tcp_src_port}, f.src_hi, f.src_lo)) begin
						v.full = block_add(f.src_hi, f.src_lo);
						v.notify = 1'b1;
					end else if (f.mac != MAC_BCAST && f.mac[47:32] != MCAST_PFX) begin
						v.full = mac_learn(f.mac, f.peer_ep);
						v.action = ACT_TAP;
					end
				end
			end
			FUNC_NOTICE: begin
				v.full = block_add(f.src_hi, f.src_lo);
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic frame_t noise_frame();
		frame_t f;
		f.func = 2'($urandom_range(3));
		f.ethertype = $urandom_range(3) == 0 ? ETH_IPV6 : 16'($urandom());
		f.ip_proto = $urandom_range(1) ? PROTO_TCP : 8'($urandom());
		f.syn_flag = 1'($urandom_range(1));
		f.tcp_src_port = 16'($urandom());
		f.dst_port = 16'($urandom());
		f.src_hi = rand64();
		f.src_lo = rand64();
		f.dst_hi = rand64();
		f.dst_lo = rand64();
		f.mac = 48'(rand64());
		f.peer_ep = 48'(rand64());
		return f;
	endfunction

	function automatic frame_t traffic_frame();
		frame_t f;
		int r, a;
		f = noise_frame();
		r = $urandom_range(99);
		a = $urandom_range(5);
		if (r < 10) return f;
		f.ethertype = $urandom_range(9) == 0 ? 16'($urandom()) : ETH_IPV6;
		f.ip_proto = $urandom_range(9) < 7 ? PROTO_TCP : 8'($urandom());
		f.mac = mac_pool[$urandom_range(39)];
		f.peer_ep = ep_pool[$urandom_range(7)];
		if (r < 40) begin
			f.func = FUNC_OUT;
			f.syn_flag = $urandom_range(9) < 7;
			f.tcp_src_port = lport_pool[$urandom_range(3)];
			f.dst_port = rport_pool[$urandom_range(3)];
			f.dst_hi = rem_hi[a];
			f.dst_lo = rem_lo[a];
		end else if (r < 86) begin
			f.func = FUNC_IN;
			f.dst_port = lport_pool[$urandom_range(3)];
			f.tcp_src_port = rport_pool[$urandom_range(3)];
			f.src_hi = rem_hi[a];
			f.src_lo = rem_lo[a];
			if ($urandom_range(9) < 9) begin
				f.dst_hi = lcl_hi;
				f.dst_lo = lcl_lo;
			end
			case ($urandom_range(14))
				0: f.mac = MAC_BCAST;
				1: f.mac[47:32] = MCAST_PFX;
				2: f.mac = 48'(rand64());
				default: begin
				end
			endcase
		end else if (r < 95) begin
			f.func = FUNC_NOTICE;
			if ($urandom_range(3) == 0) begin
				f.src_hi = rem_hi[a];
				f.src_lo = rem_lo[a];
			end
		end else begin
			f.func = FUNC_UNUSED;
		end
		return f;
	endfunction

	function automatic frame_t mk(logic [1:0] fn, logic [15:0] et, logic [7:0] nh,
			logic syn, int ai, logic to_local, logic [47:0] m);
		frame_t f;
		f = '{default: '0};
		f.func = fn;
		f.ethertype = et;
		f.ip_proto = nh;
		f.syn_flag = syn;
		f.mac = m;
		f.peer_ep = ep_pool[ai];
		if (fn == FUNC_OUT) begin
			f.tcp_src_port = lport_pool[0];
			f.dst_port = rport_pool[0];
			f.dst_hi = rem_hi[ai];
			f.dst_lo = rem_lo[ai];
		end else begin
			f.dst_port = lport_pool[0];
			f.tcp_src_port = rport_pool[0];
			f.src_hi = rem_hi[ai];
			f.src_lo = rem_lo[ai];
			f.dst_hi = to_local ? lcl_hi : ~lcl_hi;
			f.dst_lo = to_local ? lcl_lo : lcl_lo;
		end
		return f;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (start && !busy)
			expected_verdicts.push_back(filter_decide(cur));
		if (!start || !busy) begin
			if (arst_n && frame_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
				cur <= frame_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict word with no expectation waiting");
				errors++;
			end else begin
				e = expected_verdicts.pop_front();
				if (action !== e.action) begin
					$error("action: expected %0d, actual %0d", e.action, action);
					errors++;
				end
				if (out_endpoint !== e.endpoint) begin
					$error("out_endpoint: expected %h, actual %h", e.endpoint, out_endpoint);
					errors++;
				end
				if (notify_peers !== e.notify) begin
					$error("notify_peers: expected %b, actual %b", e.notify, notify_peers);
					errors++;
				end
				if (table_full !== e.full) begin
					$error("table_full: expected %b, actual %b", e.full, table_full);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LOCAL_HI: lcl_hi = val;
			REG_LOCAL_LO: lcl_lo = val;
			default: bcast_ep = val[47:0];
		endcase
	endtask

	task automatic configure(logic [63:0] hi, logic [63:0] lo, logic [63:0] ep);
		write_reg(REG_LOCAL_HI, hi);
		write_reg(REG_LOCAL_LO, lo);
		write_reg(REG_BCAST_EP, ep);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (frame_queue.size() > 0 || start || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int pcts[4];
		pcts = '{0, 77, 0, 28};
		for (int i = 0; i < NMAC; i++) mac_v[i] = 1'b0;
		for (int i = 0; i < NCONN; i++) conn_v[i] = 1'b0;
		for (int i = 0; i < NBLK; i++) blk_v[i] = 1'b0;
		for (int i = 0; i < 40; i++) mac_pool[i] = {8'($urandom_range(255) & 8'hfe), 40'(i * 977 + 1)};
		mac_pool[0] = '0;
		mac_pool[1] = 48'hfeffffffffff;
		for (int i = 0; i < 8; i++) ep_pool[i] = 48'(rand64());
		ep_pool[0] = '0;
		ep_pool[1] = '1;
		for (int i = 0; i < 6; i++) begin
			rem_hi[i] = rand64();
			rem_lo[i] = rand64();
		end
		rem_hi[0] = '0;
		rem_lo[0] = '0;
		rem_hi[1] = '1;
		rem_lo[1] = '1;
		for (int i = 0; i < 4; i++) begin
			lport_pool[i] = 16'($urandom());
			rport_pool[i] = 16'($urandom());
		end
		lport_pool[0] = 16'hffff;
		rport_pool[0] = 16'h0000;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		configure(rand64(), rand64(), rand64());

		frame_queue.push_back(mk(FUNC_OUT, ETH_IPV6, PROTO_TCP, 1'b0, 2, 1'b1, mac_pool[5]));
		frame_queue.push_back(mk(FUNC_OUT, ETH_IPV6, PROTO_TCP, 1'b1, 2, 1'b1, mac_pool[5]));
		frame_queue.push_back(mk(FUNC_OUT, ETH_IPV6, PROTO_TCP, 1'b1, 2, 1'b1, mac_pool[5]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, PROTO_TCP, 1'b1, 2, 1'b1, mac_pool[5]));
		frame_queue.push_back(mk(FUNC_OUT, ETH_IPV6, 8'd17, 1'b1, 2, 1'b1, mac_pool[5]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd17, 1'b0, 3, 1'b1, mac_pool[6]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd17, 1'b0, 3, 1'b1, MAC_BCAST));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd17, 1'b0, 3, 1'b1, 48'h333300000001));
		frame_queue.push_back(mk(FUNC_IN, 16'h0800, PROTO_TCP, 1'b0, 3, 1'b1, mac_pool[7]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd17, 1'b0, 3, 1'b0, mac_pool[7]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, PROTO_TCP, 1'b0, 4, 1'b1, mac_pool[8]));
		frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd17, 1'b0, 4, 1'b1, mac_pool[8]));
		frame_queue.push_back(mk(FUNC_NOTICE, 16'h0, 8'h0, 1'b0, 0, 1'b1, '0));
		frame_queue.push_back(mk(FUNC_NOTICE, 16'h0, 8'h0, 1'b0, 0, 1'b1, '0));
		frame_queue.push_back(mk(FUNC_NOTICE, 16'hffff, 8'hff, 1'b1, 1, 1'b1, '1));
		frame_queue.push_back(mk(FUNC_UNUSED, ETH_IPV6, PROTO_TCP, 1'b1, 5, 1'b1, mac_pool[9]));
		frame_queue.push_back(mk(FUNC_OUT, 16'hffff, 8'hff, 1'b1, 1, 1'b1, '1));
		frame_queue.push_back(mk(FUNC_OUT, 16'h0000, 8'h00, 1'b0, 0, 1'b1, '0));
		for (int i = 10; i < 16; i++)
			frame_queue.push_back(mk(FUNC_IN, ETH_IPV6, 8'd58, 1'b0, 5, 1'b1, mac_pool[i]));
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: configure('1, '1, '1);
				1: configure(rand64(), rand64(), rand64());
				2: configure('0, '0, '0);
				default: configure(rand64(), rand64(), 64'(48'($urandom())));
			endcase
			idle_pct = pcts[p];
			for (int i = 0; i < 100; i++) frame_queue.push_back(traffic_frame());
			drain();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

>>> stateful_syn_filter_bridge_core.f
src/ssfb_pkg.sv
src/stateful_syn_filter_bridge_core.sv
src/ssfb_checker.sv
dv/stateful_syn_filter_bridge_core_tb.sv
